### rtl/core/dhfk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dhfk_pkg;

	localparam int NUM_JOINTS  = 7;
	localparam int ANGLE_BITS  = 16;
	localparam int FRAC_BITS   = 14;
	localparam int OFFSET_BITS = 21;
	localparam int ROT_BITS    = FRAC_BITS + 2;
	localparam int POS_BITS    = 24;
	localparam int CFG_IDX_BITS = 3;

	// working widths: rotation carries headroom for rounding creep
	localparam int RW  = FRAC_BITS + 3;
	localparam int PRW = 2 * FRAC_BITS + 6;
	localparam int PW  = OFFSET_BITS + FRAC_BITS + 6;

	localparam logic [30:0] Q30_ONE = 31'h4000_0000;
	localparam logic [30:0] C11 = 31'd3864;
	localparam logic [30:0] COEF [0:4] = '{31'd172272, 31'd5026995, 31'd85569306,
		31'd693598668, 31'd1686629713};

	localparam int SH = 30 - FRAC_BITS;
	localparam logic [31:0] SIN_RADD = (32'd1 << SH) >> 1;

	typedef struct packed {
		logic signed [ANGLE_BITS-1:0] angle_one;
		logic signed [ANGLE_BITS-1:0] angle_two;
		logic signed [ANGLE_BITS-1:0] angle_three;
		logic signed [ANGLE_BITS-1:0] angle_four;
		logic signed [ANGLE_BITS-1:0] angle_five;
		logic signed [ANGLE_BITS-1:0] angle_six;
		logic signed [ANGLE_BITS-1:0] angle_seven;
	} ang_word_t;

	typedef struct packed {
		logic signed [ROT_BITS-1:0] rot_xx;
		logic signed [ROT_BITS-1:0] rot_xy;
		logic signed [ROT_BITS-1:0] rot_xz;
		logic signed [ROT_BITS-1:0] rot_yx;
		logic signed [ROT_BITS-1:0] rot_yy;
		logic signed [ROT_BITS-1:0] rot_yz;
		logic signed [ROT_BITS-1:0] rot_zx;
		logic signed [ROT_BITS-1:0] rot_zy;
		logic signed [ROT_BITS-1:0] rot_zz;
		logic signed [POS_BITS-1:0] pos_x;
		logic signed [POS_BITS-1:0] pos_y;
		logic signed [POS_BITS-1:0] pos_z;
	} pose_word_t;

	// one polynomial lane: argument, its square, running value
	typedef struct packed {
		logic [30:0] x;
		logic [30:0] y;
		logic [30:0] p;
	} evl_t;

	function automatic logic [30:0] q30_mul(input logic [30:0] a, input logic [30:0] b);
		logic [62:0] t;
		t = 63'(a) * 63'(b) + (63'd1 << 29);
		return t[60:30];
	endfunction

	function automatic logic [FRAC_BITS:0] sin_round(input logic [30:0] s);
		logic [30:0] c;
		logic [31:0] t;
		c = (s > Q30_ONE) ? Q30_ONE : s;
		t = (32'(c) + SIN_RADD) >> SH;
		return t[FRAC_BITS:0];
	endfunction

	function automatic logic signed [RW-1:0] rot_round(input logic signed [PRW-1:0] t);
		logic signed [PRW-1:0] s;
		s = (t + (PRW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		return s[RW-1:0];
	endfunction

endpackage
`default_nettype wire

### rtl/core/dh_forward_kinematics_7dof.sv
`timescale 1ns / 1ps
`default_nettype none
// channel | valid     | stall      | word
// angles  | ang_valid | ang_stall  | ang_word  (seven joint angles)
// pose    | pose_valid| pose_stall | pose_word (rotation Q1.14, position um)
// One word enters per cycle unless ang_stall is high; pose_valid rises once a
// word has passed 8 sine polynomial stages, 8 frame stages, output register.
// The polynomial multiplier chain sets the depth; each frame is one stage.
// Reset clears valid bits and offsets. Stalling a valid pose freezes the pipe.
module dh_forward_kinematics_7dof (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               ang_valid,
	output logic                              ang_stall,
	input  dhfk_pkg::ang_word_t               ang_word,
	output logic                              pose_valid,
	input  wire                               pose_stall,
	output dhfk_pkg::pose_word_t              pose_word,
	input  wire                               cfg_we,
	input  wire [dhfk_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire [dhfk_pkg::OFFSET_BITS-1:0]   cfg_data
);
	import dhfk_pkg::*;

	localparam int NE = 2 * NUM_JOINTS;
	localparam int NV = 16;
	localparam logic signed [RW-1:0] ONE_R = RW'(1) <<< FRAC_BITS;
	localparam logic signed [PW-FRAC_BITS-1:0] PMAX = (PW-FRAC_BITS)'((1 << (POS_BITS-1)) - 1);
	localparam logic signed [PW-FRAC_BITS-1:0] PMIN = -PMAX - (PW-FRAC_BITS)'(1);

	logic signed [OFFSET_BITS-1:0] offset_q [0:NUM_JOINTS];
	logic adv;
	logic [NV-1:0] vld_s;
	logic pose_valid_q;
	pose_word_t pose_q;

	evl_t pl_s [0:7][0:NE-1];
	logic [1:0] quad_s [0:7][0:NUM_JOINTS-1];

	logic signed [FRAC_BITS+1:0] fr_sn_s [0:7][0:NUM_JOINTS-1];
	logic signed [FRAC_BITS+1:0] fr_cs_s [0:7][0:NUM_JOINTS-1];
	logic signed [RW-1:0] fr_rot_s [0:7][0:8];
	logic signed [PW-1:0] fr_pos_s [0:7][0:2];

	logic [ANGLE_BITS-1:0] ang [0:NUM_JOINTS-1];

	assign adv        = !(pose_valid_q && pose_stall);
	assign ang_stall  = !adv;
	assign pose_valid = pose_valid_q;
	assign pose_word  = pose_q;

	assign ang[0] = ang_word.angle_one;
	assign ang[1] = ang_word.angle_two;
	assign ang[2] = ang_word.angle_three;
	assign ang[3] = ang_word.angle_four;
	assign ang[4] = ang_word.angle_five;
	assign ang[5] = ang_word.angle_six;
	assign ang[6] = ang_word.angle_seven;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= NUM_JOINTS; i++) offset_q[i] <= '0;
		end else if (cfg_we) begin
			offset_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			pose_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s <= {vld_s[NV-2:0], ang_valid};
			pose_valid_q <= vld_s[NV-1];
		end
	end

	// sine/cosine polynomial lanes: even lane sine arg, odd lane cosine arg
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < NUM_JOINTS; j++) begin
				pl_s[0][2*j].x   <= 31'(ang[j][ANGLE_BITS-3:0]) << (32 - ANGLE_BITS);
				pl_s[0][2*j+1].x <= Q30_ONE - (31'(ang[j][ANGLE_BITS-3:0]) << (32 - ANGLE_BITS));
				pl_s[0][2*j].y   <= '0;
				pl_s[0][2*j+1].y <= '0;
				pl_s[0][2*j].p   <= '0;
				pl_s[0][2*j+1].p <= '0;
				quad_s[0][j] <= ang[j][ANGLE_BITS-1 -: 2];
				for (int t = 1; t < 8; t++) quad_s[t][j] <= quad_s[t-1][j];
			end
			for (int e = 0; e < NE; e++) begin
				pl_s[1][e].x <= pl_s[0][e].x;
				pl_s[1][e].y <= q30_mul(pl_s[0][e].x, pl_s[0][e].x);
				pl_s[1][e].p <= C11;
				for (int t = 2; t < 7; t++) begin
					pl_s[t][e].x <= pl_s[t-1][e].x;
					pl_s[t][e].y <= pl_s[t-1][e].y;
					pl_s[t][e].p <= COEF[t-2] - q30_mul(pl_s[t-1][e].p, pl_s[t-1][e].y);
				end
				pl_s[7][e].x <= pl_s[6][e].x;
				pl_s[7][e].y <= pl_s[6][e].y;
				pl_s[7][e].p <= 31'(sin_round(q30_mul(pl_s[6][e].x, pl_s[6][e].p)));
			end
		end
	end

	// quadrant fold and joint flip
	logic signed [FRAC_BITS+1:0] map_sn [0:NUM_JOINTS-1];
	logic signed [FRAC_BITS+1:0] map_cs [0:NUM_JOINTS-1];

	always_comb begin
		logic signed [FRAC_BITS+1:0] a, b;
		for (int j = 0; j < NUM_JOINTS; j++) begin
			a = $signed({1'b0, pl_s[7][2*j].p[FRAC_BITS:0]});
			b = $signed({1'b0, pl_s[7][2*j+1].p[FRAC_BITS:0]});
			case (quad_s[7][j])
				2'd0: begin map_sn[j] = a;  map_cs[j] = b;  end
				2'd1: begin map_sn[j] = b;  map_cs[j] = -a; end
				2'd2: begin map_sn[j] = -a; map_cs[j] = -b; end
				default: begin map_sn[j] = -b; map_cs[j] = a; end
			endcase
			if (j >= 1) begin
				map_sn[j] = -map_sn[j];
				map_cs[j] = -map_cs[j];
			end
		end
	end

	// frame k takes fr stage k to k+1
	logic signed [RW-1:0] nrot [0:NUM_JOINTS-1][0:8];
	logic signed [PW-1:0] npos [0:NUM_JOINTS-1][0:2];

	always_comb begin
		logic signed [RW-1:0] u, v, w;
		logic signed [PRW-1:0] sn_p, cs_p;
		for (int k = 0; k < NUM_JOINTS; k++) begin
			sn_p = PRW'(fr_sn_s[k][k]);
			cs_p = PRW'(fr_cs_s[k][k]);
			for (int r = 0; r < 3; r++) begin
				u = fr_rot_s[k][3*r];
				v = fr_rot_s[k][3*r+1];
				w = fr_rot_s[k][3*r+2];
				npos[k][r] = fr_pos_s[k][r] + PW'(offset_q[k+1]) * PW'(w);
				nrot[k][3*r] = rot_round(cs_p * PRW'(u) + sn_p * PRW'(v));
				if (k < NUM_JOINTS - 1) begin
					nrot[k][3*r+1] = w;
					nrot[k][3*r+2] = rot_round(sn_p * PRW'(u) - cs_p * PRW'(v));
				end else begin
					nrot[k][3*r+1] = rot_round(sn_p * PRW'(u) - cs_p * PRW'(v));
					nrot[k][3*r+2] = -w;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < NUM_JOINTS; j++) begin
				fr_sn_s[0][j] <= map_sn[j];
				fr_cs_s[0][j] <= map_cs[j];
				for (int f = 1; f < 8; f++) begin
					fr_sn_s[f][j] <= fr_sn_s[f-1][j];
					fr_cs_s[f][j] <= fr_cs_s[f-1][j];
				end
			end
			// base frame rotation diag(1, -1, -1)
			for (int i = 0; i < 9; i++)
				fr_rot_s[0][i] <= (i == 0) ? ONE_R : ((i == 4 || i == 8) ? -ONE_R : '0);
			fr_pos_s[0][0] <= '0;
			fr_pos_s[0][1] <= '0;
			fr_pos_s[0][2] <= PW'(offset_q[0]) <<< FRAC_BITS;
			for (int k = 0; k < NUM_JOINTS; k++) begin
				for (int i = 0; i < 9; i++) fr_rot_s[k+1][i] <= nrot[k][i];
				for (int r = 0; r < 3; r++) fr_pos_s[k+1][r] <= npos[k][r];
			end
		end
	end

	// clamp and saturate into the output register
	logic signed [ROT_BITS-1:0] orot [0:8];
	logic signed [POS_BITS-1:0] opos [0:2];

	always_comb begin
		logic signed [RW-1:0] e;
		logic signed [PW-1:0] pr;
		logic signed [PW-FRAC_BITS-1:0] pw;
		for (int i = 0; i < 9; i++) begin
			e = fr_rot_s[7][i];
			if (e > ONE_R) e = ONE_R;
			if (e < -ONE_R) e = -ONE_R;
			orot[i] = e[ROT_BITS-1:0];
		end
		for (int r = 0; r < 3; r++) begin
			pr = (fr_pos_s[7][r] + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
			pw = pr[PW-FRAC_BITS-1:0];
			if (pw > PMAX) pw = PMAX;
			if (pw < PMIN) pw = PMIN;
			opos[r] = pw[POS_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pose_q.rot_xx <= orot[0];
			pose_q.rot_xy <= orot[1];
			pose_q.rot_xz <= orot[2];
			pose_q.rot_yx <= orot[3];
			pose_q.rot_yy <= orot[4];
			pose_q.rot_yz <= orot[5];
			pose_q.rot_zx <= orot[6];
			pose_q.rot_zy <= orot[7];
			pose_q.rot_zz <= orot[8];
			pose_q.pos_x  <= opos[0];
			pose_q.pos_y  <= opos[1];
			pose_q.pos_z  <= opos[2];
		end
	end

`ifndef NO_ASSERTIONS
	a_rot_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		pose_valid |-> (pose_word.rot_xx <= 16'sd16384 && pose_word.rot_xx >= -16'sd16384
			&& pose_word.rot_zz <= 16'sd16384 && pose_word.rot_zz >= -16'sd16384))
		else $error("rotation entry out of range");

	a_tail_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[NV-1] && !ang_stall) |=> pose_valid)
		else $error("word lost at output register");

	a_pipe_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		ang_stall |=> $stable(vld_s))
		else $error("pipe moved during stall");
`endif

endmodule
`default_nettype wire

### verif/dh_forward_kinematics_7dof_tb.sv
`timescale 1ns / 1ps
module dh_forward_kinematics_7dof_tb;
	import dhfk_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 40;
	localparam int LONG_HOLD = 90;
	localparam longint unsigned ONE_Q30 = 64'd1 << 30;
	localparam longint ONE_ROT = 64'd1 << FRAC_BITS;

	class pose_scoreboard;
		longint offs[NUM_JOINTS + 1];
		pose_word_t pending_poses[$];
		int errors;

		function new();
			foreach (offs[i]) offs[i] = 0;
			errors = 0;
		endfunction

		function void set_offset(int idx, logic [OFFSET_BITS-1:0] d);
			offs[idx] = longint'(signed'(d));
		endfunction

		function longint unsigned qmul(longint unsigned a, longint unsigned b);
			return (a * b + (64'd1 << 29)) >> 30;
		endfunction

		function longint unsigned quarter_sin(longint unsigned x);
			longint unsigned y, p;
			y = qmul(x, x);
			p = 64'd3864;
			p = 64'd172272 - qmul(p, y);
			p = 64'd5026995 - qmul(p, y);
			p = 64'd85569306 - qmul(p, y);
			p = 64'd693598668 - qmul(p, y);
			p = 64'd1686629713 - qmul(p, y);
			p = qmul(x, p);
			return (p > ONE_Q30) ? ONE_Q30 : p;
		endfunction

		function void sin_cos(logic [ANGLE_BITS-1:0] ang, output longint sn, output longint cs);
			longint unsigned x;
			longint a, b;
			x = longint'(ang[ANGLE_BITS-3:0]) << (32 - ANGLE_BITS);
			a = longint'((quarter_sin(x) + (64'd1 << 15)) >> 16);
			b = longint'((quarter_sin(ONE_Q30 - x) + (64'd1 << 15)) >> 16);
			case (ang[ANGLE_BITS-1:ANGLE_BITS-2])
				2'd0: begin sn = a; cs = b; end
				2'd1: begin sn = b; cs = -a; end
				2'd2: begin sn = -a; cs = -b; end
				default: begin sn = -b; cs = a; end
			endcase
		endfunction

		function longint rnd(longint t);
			return (t + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		endfunction

		function pose_word_t pose_of(ang_word_t a);
			logic [ANGLE_BITS-1:0] ang [NUM_JOINTS];
			longint r [3][3];
			longint p [3];
			longint sn, cs, u, v, w, e;
			pose_word_t o;
			ang = '{a.angle_one, a.angle_two, a.angle_three, a.angle_four,
				a.angle_five, a.angle_six, a.angle_seven};
			foreach (r[i, j]) r[i][j] = 0;
			r[0][0] = ONE_ROT;
			r[1][1] = -ONE_ROT;
			r[2][2] = -ONE_ROT;
			p[0] = 0;
			p[1] = 0;
			p[2] = offs[0] * ONE_ROT;
			for (int i = 1; i <= NUM_JOINTS; i++) begin
				sin_cos(ang[i-1], sn, cs);
				if (i >= 2) begin
					sn = -sn;
					cs = -cs;
				end
				for (int k = 0; k < 3; k++) p[k] += offs[i] * r[k][2];
				for (int k = 0; k < 3; k++) begin
					u = r[k][0];
					v = r[k][1];
					w = r[k][2];
					r[k][0] = rnd(cs * u + sn * v);
					if (i < NUM_JOINTS) begin
						r[k][1] = w;
						r[k][2] = rnd(sn * u - cs * v);
					end else begin
						r[k][1] = rnd(sn * u - cs * v);
						r[k][2] = -w;
					end
				end
			end
			foreach (r[i, j]) begin
				if (r[i][j] > ONE_ROT) r[i][j] = ONE_ROT;
				if (r[i][j] < -ONE_ROT) r[i][j] = -ONE_ROT;
			end
			foreach (p[k]) begin
				e = rnd(p[k]);
				if (e > 64'sd8388607) e = 64'sd8388607;
				if (e < -64'sd8388608) e = -64'sd8388608;
				p[k] = e;
			end
			o.rot_xx = r[0][0][ROT_BITS-1:0];
			o.rot_xy = r[0][1][ROT_BITS-1:0];
			o.rot_xz = r[0][2][ROT_BITS-1:0];
			o.rot_yx = r[1][0][ROT_BITS-1:0];
			o.rot_yy = r[1][1][ROT_BITS-1:0];
			o.rot_yz = r[1][2][ROT_BITS-1:0];
			o.rot_zx = r[2][0][ROT_BITS-1:0];
			o.rot_zy = r[2][1][ROT_BITS-1:0];
			o.rot_zz = r[2][2][ROT_BITS-1:0];
			o.pos_x = p[0][POS_BITS-1:0];
			o.pos_y = p[1][POS_BITS-1:0];
			o.pos_z = p[2][POS_BITS-1:0];
			return o;
		endfunction

		function void add_angles(ang_word_t a);
			pending_poses.push_back(pose_of(a));
		endfunction

		function void check_pose(pose_word_t got);
			pose_word_t want;
			bit bad;
			if (pending_poses.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected pose word %h", got);
				return;
			end
			want = pending_poses.pop_front();
			bad = 0;
			if (got.rot_xx !== want.rot_xx) bad = 1;
			if (got.rot_xy !== want.rot_xy) bad = 1;
			if (got.rot_xz !== want.rot_xz) bad = 1;
			if (got.rot_yx !== want.rot_yx) bad = 1;
			if (got.rot_yy !== want.rot_yy) bad = 1;
			if (got.rot_yz !== want.rot_yz) bad = 1;
			if (got.rot_zx !== want.rot_zx) bad = 1;
			if (got.rot_zy !== want.rot_zy) bad = 1;
			if (got.rot_zz !== want.rot_zz) bad = 1;
			if (got.pos_x !== want.pos_x) bad = 1;
			if (got.pos_y !== want.pos_y) bad = 1;
			if (got.pos_z !== want.pos_z) bad = 1;
			if (bad) begin
				errors++;
				if (errors <= 10)
					$display("pose mismatch: expected %p got %p", want, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic ang_valid;
	logic ang_stall;
	ang_word_t ang_word;
	logic pose_valid;
	logic pose_stall;
	pose_word_t pose_word;
	logic cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [OFFSET_BITS-1:0] cfg_data;

	pose_scoreboard sb;
	int send_pct;
	int recv_pct;
	bit hold_req;
	int hold_left;
	int quiet_cycles;

	dh_forward_kinematics_7dof dut (
		.clk(clk),
		.arst_n(arst_n),
		.ang_valid(ang_valid),
		.ang_stall(ang_stall),
		.ang_word(ang_word),
		.pose_valid(pose_valid),
		.pose_stall(pose_stall),
		.pose_word(pose_word),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// receiver side: random stall, or a long counted hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 0;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			pose_stall <= 1'b1;
		end else begin
			pose_stall <= ($urandom_range(99) < recv_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (ang_valid && !ang_stall) sb.add_angles(ang_word);
			if (pose_valid && !pose_stall) sb.check_pose(pose_word);
			if ((ang_valid && !ang_stall) || (pose_valid && !pose_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	function automatic logic [ANGLE_BITS-1:0] pick_angle();
		logic [ANGLE_BITS-1:0] corners [7];
		corners = '{16'h0000, 16'h4000, 16'hc000, 16'h8000, 16'h7fff, 16'h0001, 16'hffff};
		if ($urandom_range(99) < 20) return corners[$urandom_range(6)];
		return ANGLE_BITS'($urandom);
	endfunction

	task automatic send_word(ang_word_t w);
		while ($urandom_range(99) < send_pct) begin
			ang_valid <= 1'b0;
			@(negedge clk);
		end
		ang_valid <= 1'b1;
		ang_word <= w;
		do @(posedge clk); while (ang_stall);
		@(negedge clk);
	endtask

	task automatic send_all_same(logic [ANGLE_BITS-1:0] a);
		send_word('{a, a, a, a, a, a, a});
	endtask

	task automatic send_random();
		send_word('{pick_angle(), pick_angle(), pick_angle(), pick_angle(),
			pick_angle(), pick_angle(), pick_angle()});
	endtask

	task automatic wait_drained();
		ang_valid <= 1'b0;
		while (sb.pending_poses.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// mode: 0 max, 1 min, 2 random, 3 random extremes
	task automatic write_offsets(int mode);
		logic [OFFSET_BITS-1:0] d;
		for (int i = 0; i <= NUM_JOINTS; i++) begin
			case (mode)
				0: d = {1'b0, {(OFFSET_BITS-1){1'b1}}};
				1: d = {1'b1, {(OFFSET_BITS-1){1'b0}}};
				2: d = OFFSET_BITS'($urandom);
				default: d = $urandom_range(1) ? {1'b0, {(OFFSET_BITS-1){1'b1}}}
					: {1'b1, {(OFFSET_BITS-1){1'b0}}};
			endcase
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_BITS'(i);
			cfg_data <= d;
			sb.set_offset(i, d);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		ang_valid = 1'b0;
		ang_word = '0;
		pose_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_pct = 0;
		recv_pct = 0;
		hold_req = 0;
		hold_left = 0;
		quiet_cycles = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset offsets first, then a random set
		for (int k = 0; k < 2; k++) begin
			if (k == 1) write_offsets(2);
			send_all_same(16'h0000);
			send_all_same(16'h4000);
			send_all_same(16'hc000);
			send_all_same(16'h8000);
			send_all_same(16'h7fff);
			send_all_same(16'h0001);
			send_all_same(16'hffff);
			send_all_same(16'h2000);
			send_word('{16'h7fff, 16'h8000, 16'h0000, 16'h4000, 16'hc000, 16'h1234,
				16'hedcb});
			send_word('{16'h4000, 16'h4000, 16'h4000, 16'h4000, 16'hc000, 16'hc000,
				16'hc000});
			wait_drained();
		end

		for (int ph = 0; ph < 6; ph++) begin
			write_offsets(ph < 2 ? ph : (ph == 5 ? 3 : 2));
			case (ph / 2)
				0: begin send_pct = 30; recv_pct = 45; end
				1: begin send_pct = 45; recv_pct = 30; end
				default: begin send_pct = 0; recv_pct = 0; end
			endcase
			for (int n = 0; n < 237; n++) begin
				// a long receiver hold-off lets the pipe fill and push back
				if (n == 60 && (ph == 0 || ph == 4)) begin
					ang_valid <= 1'b0;
					@(posedge clk);
					hold_req = 1;
					@(negedge clk);
				end
				// let the block run dry before carrying on
				if (n == 150) wait_drained();
				send_random();
			end
			wait_drained();
		end

		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
